### rtl/sss_pkg.sv
// Shared types, codes and constants of the stepper step sequencer.
`default_nettype none
package sss_pkg;

	localparam int unsigned POSITION_MODULUS = 2047;
	localparam int unsigned POS_W = $clog2(POSITION_MODULUS);

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(POSITION_MODULUS - 1);

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef logic [3:0] phase_t;
	localparam phase_t PHASE_RESET = 4'h8;
	localparam phase_t PHASE_FIRST = 4'h1;

	// Run mode codes. The unused code behaves like a counted move.
	typedef logic [1:0] run_mode_t;
	localparam run_mode_t MODE_COUNTED    = 2'd0;
	localparam run_mode_t MODE_CONTINUOUS = 2'd1;
	localparam run_mode_t MODE_STOP_AFTER = 2'd2;

	// Command codes of an input request.
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Direction codes.
	localparam logic DIR_CCW = 1'b0;
	localparam logic DIR_CW  = 1'b1;

	// Configuration register indexes.
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	localparam cfg_index_t CFG_RUN_MODE  = 2'd0;
	localparam cfg_index_t CFG_DIRECTION = 2'd1;
	localparam cfg_index_t CFG_DELAY     = 2'd2;

	typedef struct packed {
		phase_t           coil_phase;
		logic [POS_W-1:0] position;
		logic             moving;
		logic             stepped;
	} result_t;

endpackage
`default_nettype wire

### rtl/sss_if.sv
// Channel interfaces of the stepper step sequencer: input, result and configuration.
`default_nettype none
interface sss_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] step_target;

	modport source (output valid, output command, output step_target, input ready);
	modport sink (input valid, input command, input step_target, output ready);
endinterface

interface sss_out_if;
	logic                      valid;
	logic                      ready;
	sss_pkg::phase_t           coil_phase;
	logic [sss_pkg::POS_W-1:0] position;
	logic                      moving;
	logic                      stepped;

	modport source (output valid, output coil_phase, output position, output moving,
		output stepped, input ready);
	modport sink (input valid, input coil_phase, input position, input moving,
		input stepped, output ready);
endinterface

interface sss_cfg_if;
	logic                           valid;
	logic                           ready;
	sss_pkg::cfg_index_t            index;
	logic [sss_pkg::CFG_DATA_W-1:0] value;

	modport source (output valid, output index, output value, input ready);
	modport sink (input valid, input index, input value, output ready);
endinterface
`default_nettype wire

### rtl/stepper_step_sequencer_core.sv
// Top level of the stepper step sequencer: step timing, coil phase, position and result buffer.
`default_nettype none
// The sequencer takes one request per clock cycle on in_ch while ready: a start command
// that loads a step target, or a timer tick that, while a move is armed, advances the delay
// counter and, when the counter meets delay_ticks, rotates the one-hot coil phase and,
// outside continuous mode, moves the position. Every request gives exactly one registered
// result on out_ch. The state update is combinational, so requests can follow each other in
// every cycle. Results go into a two-entry output buffer; in_ch.ready drops only while both
// entries are full, so the block keeps accepting while one finished result waits downstream.
// Throughput is one request per cycle whenever out_ch is ready. Configuration
// writes on cfg_ch are always accepted and should only be made while the block is idle.
module stepper_step_sequencer_core (
	input  wire      clk,
	input  wire      arst_n,
	sss_in_if.sink   in_ch,
	sss_out_if.source out_ch,
	sss_cfg_if.sink  cfg_ch
);

	// Configuration registers.
	sss_pkg::run_mode_t run_mode_q;
	logic               direction_q;
	logic [15:0]        delay_ticks_q;

	// Sequencer state.
	sss_pkg::phase_t             phase_q;
	logic [15:0]                 delay_count_q;
	logic [sss_pkg::POS_W-1:0]   position_q;
	logic [15:0]                 step_count_q;
	logic [15:0]                 target_q;
	logic                        moving_q;
	logic                        running_q;

	// Next-state values for an accepted request.
	sss_pkg::phase_t             phase_d;
	logic [15:0]                 delay_count_d;
	logic [sss_pkg::POS_W-1:0]   position_d;
	logic [15:0]                 step_count_d;
	logic [15:0]                 target_d;
	logic                        moving_d;
	logic                        running_d;
	logic                        stepped_d;

	sss_pkg::phase_t             phase_cw;
	sss_pkg::phase_t             phase_ccw;
	logic [sss_pkg::POS_W-1:0]   position_up;
	logic [sss_pkg::POS_W-1:0]   position_down;
	logic [15:0]                 step_count_inc;
	logic                        delay_hit;

	// Output buffer: the head register drives out_ch, the skid entry catches a result
	// that arrives while the head is stalled.
	sss_pkg::result_t out_data_q;
	logic             out_valid_q;
	sss_pkg::result_t skid_data_q;
	logic             skid_valid_q;
	sss_pkg::result_t result_new;

	logic in_accept;
	logic out_pop;

	assign in_ch.ready  = ~skid_valid_q;
	assign cfg_ch.ready = 1'b1;
	assign in_accept    = in_ch.valid & in_ch.ready;
	assign out_pop      = out_valid_q & out_ch.ready;

	// Configuration writes. An index beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_mode_q    <= sss_pkg::MODE_COUNTED;
			direction_q   <= sss_pkg::DIR_CCW;
			delay_ticks_q <= '0;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				sss_pkg::CFG_RUN_MODE:  run_mode_q    <= cfg_ch.value[1:0];
				sss_pkg::CFG_DIRECTION: direction_q   <= cfg_ch.value[0];
				sss_pkg::CFG_DELAY:     delay_ticks_q <= cfg_ch.value;
				default: ;
			endcase
		end
	end

	// Phase rotations wrap around the four coils; position moves modulo the modulus.
	assign phase_cw  = (phase_q == sss_pkg::PHASE_FIRST) ? sss_pkg::PHASE_RESET
		: (phase_q >> 1);
	assign phase_ccw = (phase_q == sss_pkg::PHASE_RESET) ? sss_pkg::PHASE_FIRST
		: (phase_q << 1);
	assign position_up   = (position_q == sss_pkg::POS_LAST) ? '0 : position_q + 1'b1;
	assign position_down = (position_q == '0) ? sss_pkg::POS_LAST : position_q - 1'b1;
	assign step_count_inc = step_count_q + 16'd1;
	assign delay_hit      = (delay_count_q == delay_ticks_q);

	always_comb begin
		phase_d       = phase_q;
		delay_count_d = delay_count_q;
		position_d    = position_q;
		step_count_d  = step_count_q;
		target_d      = target_q;
		moving_d      = moving_q;
		running_d     = running_q;
		stepped_d     = 1'b0;

		if (in_ch.command == sss_pkg::CMD_START) begin
			// A start only arms the move; counters, phase and position keep their values.
			target_d  = in_ch.step_target;
			running_d = 1'b1;
			moving_d  = 1'b1;
		end else if (running_q) begin
			if (run_mode_q == sss_pkg::MODE_CONTINUOUS) begin
				if (delay_hit) begin
					phase_d       = phase_cw;
					delay_count_d = '0;
					stepped_d     = 1'b1;
				end else begin
					delay_count_d = delay_count_q + 16'd1;
				end
			end else begin
				if (delay_hit) begin
					if (direction_q == sss_pkg::DIR_CCW) begin
						phase_d    = phase_ccw;
						position_d = position_up;
					end else begin
						phase_d    = phase_cw;
						position_d = position_down;
					end
					step_count_d  = step_count_inc;
					delay_count_d = '0;
					stepped_d     = 1'b1;
					// The move ends once the step count has reached the target.
					if (target_q <= step_count_inc) begin
						step_count_d = '0;
						target_d     = '0;
						moving_d     = 1'b0;
						running_d    = 1'b0;
					end
				end else begin
					delay_count_d = delay_count_q + 16'd1;
				end
				// In stop-after-tick mode every handled tick disarms stepping.
				if (run_mode_q == sss_pkg::MODE_STOP_AFTER) begin
					running_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= sss_pkg::PHASE_RESET;
			delay_count_q <= '0;
			position_q    <= '0;
			step_count_q  <= '0;
			target_q      <= '0;
			moving_q      <= 1'b0;
			running_q     <= 1'b0;
		end else if (in_accept) begin
			phase_q       <= phase_d;
			delay_count_q <= delay_count_d;
			position_q    <= position_d;
			step_count_q  <= step_count_d;
			target_q      <= target_d;
			moving_q      <= moving_d;
			running_q     <= running_d;
		end
	end

	assign result_new = '{coil_phase: phase_d, position: position_d, moving: moving_d,
		stepped: stepped_d};

	// Valid bits of the output buffer. A request is accepted only while the skid entry is
	// empty, so a new result goes to the head when the head frees up, else to the skid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (in_accept) begin
			if (!out_valid_q || out_pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_pop) begin
			out_valid_q  <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			if (!out_valid_q || out_pop) begin
				out_data_q <= result_new;
			end else begin
				skid_data_q <= result_new;
			end
		end else if (out_pop && skid_valid_q) begin
			out_data_q <= skid_data_q;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.coil_phase = out_data_q.coil_phase;
	assign out_ch.position   = out_data_q.position;
	assign out_ch.moving     = out_data_q.moving;
	assign out_ch.stepped    = out_data_q.stepped;

endmodule
`default_nettype wire

### rtl/sss_checker.sv
// Port-level checker of the stepper step sequencer and its bind to the top level.
`default_nettype none
module sss_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            in_ready,
	input wire                            out_valid,
	input wire                            out_ready,
	input wire sss_pkg::phase_t           coil_phase,
	input wire [sss_pkg::POS_W-1:0]       position,
	input wire                            moving,
	input wire                            stepped
);

	// Every valid result drives exactly one coil.
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(coil_phase))
		else $error("coil phase is not one-hot");

	// The position stays below the modulus.
	a_position_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (position <= sss_pkg::POS_LAST))
		else $error("position out of range");

	// Input back-pressure only happens while results are waiting downstream.
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(coil_phase) && $stable(position)
			&& $stable(moving) && $stable(stepped))
		else $error("stalled result changed");

	// A result that steps the phase moves the coil drive relative to the previous result.
	a_step_changes_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid && stepped |-> coil_phase != $past(coil_phase))
		else $error("stepped result did not change the phase");

endmodule

bind stepper_step_sequencer_core sss_checker u_sss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.coil_phase (out_ch.coil_phase),
	.position   (out_ch.position),
	.moving     (out_ch.moving),
	.stepped    (out_ch.stepped)
);
`default_nettype wire

### dv/stepper_step_sequencer_core_tb.sv
// Self-checking testbench of the stepper step sequencer core.
`timescale 1ns / 1ps
// The bench drives requests into the sequencer, predicts every result with its own model of
// the step timing, coil phase and position, and compares each result field by field with
// the oldest prediction. The tests cover the named corner cases first, then back pressure,
// then long random runs of start-and-tick sequences under several register settings, and
// last a delay that is lowered below the running delay counter.
module stepper_step_sequencer_core_tb;

	// The run mode field has a fourth code that the package leaves unnamed. It must act
	// like a counted move.
	localparam sss_pkg::run_mode_t MODE_SPARE = 2'd3;

	// A run that makes no progress for this many cycles has hung. The longest quiet
	// stretch in a correct run is the receiver hold-off below.
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int MAX_GAP = 17;
	localparam int MAX_REPORTS = 10;

	logic clk;
	logic arst_n;

	sss_in_if  in_ch ();
	sss_out_if out_ch ();
	sss_cfg_if cfg_ch ();

	stepper_step_sequencer_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Register copy of the bench. It follows every accepted configuration write.
	sss_pkg::run_mode_t mode_cfg  = sss_pkg::MODE_COUNTED;
	logic               dir_cfg   = sss_pkg::DIR_CCW;
	logic [15:0]        delay_cfg = '0;

	// Sequencer state as the bench predicts it, starting from the reset values.
	sss_pkg::phase_t           coil_q     = sss_pkg::PHASE_RESET;
	logic [15:0]               wait_cnt   = '0;
	logic [sss_pkg::POS_W-1:0] pos_q      = '0;
	logic [15:0]               steps_done = '0;
	logic [15:0]               steps_goal = '0;
	logic                      moving_q   = 1'b0;
	logic                      running_q  = 1'b0;

	// Predicted results, oldest first. Each accepted request adds exactly one.
	sss_pkg::result_t phase_pos_queue[$];

	int mismatches = 0;
	int quiet_cycles = 0;

	// Knobs shared by the stimulus, the result sink and the tests.
	bit tx_no_gaps = 1'b0;
	bit rx_no_stalls = 1'b0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	int hold_off_req = 0;

	// Applies one request to the predicted state and returns the result that it should
	// produce. A start only arms the move; a tick while armed counts toward the delay and, when
	// the counter meets the configured delay, turns the coils by one full step.
	function automatic sss_pkg::result_t advance_sequencer(logic cmd, logic [15:0] goal);
		sss_pkg::result_t r;
		logic hit;
		r.stepped = 1'b0;
		if (cmd == sss_pkg::CMD_START) begin
			steps_goal = goal;
			running_q = 1'b1;
			moving_q = 1'b1;
		end else if (running_q) begin
			hit = (wait_cnt == delay_cfg);
			wait_cnt = hit ? 16'd0 : wait_cnt + 16'd1;
			if (mode_cfg == sss_pkg::MODE_CONTINUOUS) begin
				// Continuous mode always turns clockwise and leaves the position alone.
				if (hit) begin
					coil_q = {coil_q[0], coil_q[3:1]};
					r.stepped = 1'b1;
				end
			end else begin
				if (hit) begin
					if (dir_cfg == sss_pkg::DIR_CCW) begin
						coil_q = {coil_q[2:0], coil_q[3]};
						pos_q = (pos_q == sss_pkg::POS_LAST) ? '0 : pos_q + 1'b1;
					end else begin
						coil_q = {coil_q[0], coil_q[3:1]};
						pos_q = (pos_q == '0) ? sss_pkg::POS_LAST : pos_q - 1'b1;
					end
					steps_done = steps_done + 16'd1;
					r.stepped = 1'b1;
					// The step count is not cleared by a start, so a new move may end
					// on its very first step.
					if (steps_goal <= steps_done) begin
						steps_done = '0;
						steps_goal = '0;
						moving_q = 1'b0;
						running_q = 1'b0;
					end
				end
				if (mode_cfg == sss_pkg::MODE_STOP_AFTER)
					running_q = 1'b0;
			end
		end
		r.coil_phase = coil_q;
		r.position = pos_q;
		r.moving = moving_q;
		return r;
	endfunction

	function automatic void flag_mismatch(string what, sss_pkg::result_t want,
			sss_pkg::result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display({"%0t: %s: expected phase %h pos %0d moving %b stepped %b, ",
				"got phase %h pos %0d moving %b stepped %b"},
				$realtime, what, want.coil_phase, want.position, want.moving, want.stepped,
				got.coil_phase, got.position, got.moving, got.stepped);
	endfunction

	// Everything is sampled at the rising edge, before the block's own updates of that
	// edge are visible. Configuration writes, new requests and results are handled in
	// that order, so a request accepted at this edge is queued before any result is
	// popped.
	always @(posedge clk) begin : phase_pos_check
		sss_pkg::result_t got;
		sss_pkg::result_t want;
		if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				sss_pkg::CFG_RUN_MODE:  mode_cfg = cfg_ch.value[1:0];
				sss_pkg::CFG_DIRECTION: dir_cfg = cfg_ch.value[0];
				sss_pkg::CFG_DELAY:     delay_cfg = cfg_ch.value;
				default: ;
			endcase
		end
		if (in_ch.valid && in_ch.ready)
			phase_pos_queue.push_back(advance_sequencer(in_ch.command, in_ch.step_target));
		if (out_ch.valid && out_ch.ready) begin
			got.coil_phase = out_ch.coil_phase;
			got.position = out_ch.position;
			got.moving = out_ch.moving;
			got.stepped = out_ch.stepped;
			if (phase_pos_queue.size() == 0) begin
				want = '0;
				flag_mismatch("result without an outstanding request", want, got);
			end else begin
				want = phase_pos_queue.pop_front();
				if (got.coil_phase !== want.coil_phase || got.position !== want.position ||
						got.moving !== want.moving || got.stepped !== want.stepped)
					flag_mismatch("result mismatch", want, got);
			end
		end
	end

	// Hang detection: any accepted request, result or register write counts as progress.
	always @(posedge clk) begin : watchdog
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, quiet_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result sink. Before each result it may stall for a random number of cycles. Bursts
	// with no stalls come and go at random. A hold-off request from a test stalls it for a
	// long stretch so that the output buffer fills and the input side has to wait.
	initial begin : result_sink
		int stall;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			if (hold_off_req > 0) begin
				stall = hold_off_req;
				hold_off_req = 0;
			end else if (rx_no_stalls || rx_burst) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, MAX_GAP);
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// Offers one request and returns at the edge where it is accepted. Valid stays high
	// so that the next request can follow in the very next cycle.
	task automatic send_request(logic cmd, logic [15:0] goal);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		gap = (tx_no_gaps || tx_burst) ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.step_target <= goal;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Stops offering requests and waits until every predicted result has been checked,
	// and then lets the output buffer settle. The first edge makes sure that the last
	// accepted request has been queued before the queue is looked at.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (phase_pos_queue.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Writes all three registers back to back while the block is idle.
	task automatic program_regs(sss_pkg::run_mode_t mode, logic dir, logic [15:0] delay);
		sss_pkg::cfg_index_t idx[3];
		logic [15:0] val[3];
		wait_idle();
		idx = '{sss_pkg::CFG_RUN_MODE, sss_pkg::CFG_DIRECTION, sss_pkg::CFG_DELAY};
		val = '{16'(mode), 16'(dir), delay};
		for (int i = 0; i < 3; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.value <= val[i];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Corner cases one by one, starting from the reset settings: a tick before any start,
	// a zero target, a two-step move, a move that crosses position zero going down,
	// stop-after-tick mode with a restart, continuous mode and the spare mode code.
	task automatic test_directed_cases();
		// A tick while stepping is disabled changes nothing.
		send_request(sss_pkg::CMD_TICK, 16'hFFFF);
		// A zero target ends the move on its first step.
		send_request(sss_pkg::CMD_START, 16'h0000);
		send_request(sss_pkg::CMD_TICK, 16'h0000);
		send_request(sss_pkg::CMD_TICK, 16'h0000);
		// Two-step counter-clockwise move with no delay.
		send_request(sss_pkg::CMD_START, 16'd2);
		send_request(sss_pkg::CMD_TICK, 16'hFFFF);
		send_request(sss_pkg::CMD_TICK, 16'h0000);
		// Clockwise from position three down through zero to the top of the range.
		program_regs(sss_pkg::MODE_COUNTED, sss_pkg::DIR_CW, 16'd0);
		send_request(sss_pkg::CMD_START, 16'd4);
		repeat (4) send_request(sss_pkg::CMD_TICK, 16'h0000);
		// Stop-after-tick mode: the first tick only counts the delay and disables
		// stepping, the next one is ignored, and a fresh start lets one more tick step.
		program_regs(sss_pkg::MODE_STOP_AFTER, sss_pkg::DIR_CCW, 16'd1);
		send_request(sss_pkg::CMD_START, 16'd3);
		send_request(sss_pkg::CMD_TICK, 16'h0000);
		send_request(sss_pkg::CMD_TICK, 16'h0000);
		send_request(sss_pkg::CMD_START, 16'd3);
		send_request(sss_pkg::CMD_TICK, 16'h0000);
		// Continuous mode turns clockwise and keeps the move flag up.
		program_regs(sss_pkg::MODE_CONTINUOUS, sss_pkg::DIR_CCW, 16'd0);
		send_request(sss_pkg::CMD_START, 16'hAAAA);
		send_request(sss_pkg::CMD_TICK, 16'h5555);
		send_request(sss_pkg::CMD_TICK, 16'hAAAA);
		// The spare mode code acts as a counted move; a start in the middle of a move
		// keeps the step count, so the zero target ends at once.
		program_regs(MODE_SPARE, sss_pkg::DIR_CW, 16'd0);
		send_request(sss_pkg::CMD_START, 16'h5555);
		send_request(sss_pkg::CMD_TICK, 16'h0000);
		send_request(sss_pkg::CMD_START, 16'h0000);
		send_request(sss_pkg::CMD_TICK, 16'hFFFF);
	endtask

	// The sink stops for a long stretch while requests keep coming with no gaps, so the
	// two-entry buffer fills and the block has to drop its input ready.
	task automatic test_backpressure();
		program_regs(sss_pkg::MODE_COUNTED, sss_pkg::DIR_CCW, 16'd2);
		tx_no_gaps = 1'b1;
		hold_off_req = HOLD_OFF_CYCLES;
		send_request(sss_pkg::CMD_START, 16'd10);
		repeat (39) send_request(sss_pkg::CMD_TICK, 16'($urandom));
		tx_no_gaps = 1'b0;
	endtask

	function automatic logic [15:0] pick_target();
		case ($urandom_range(0, 15))
			0: return 16'hFFFF;
			1, 2: return 16'($urandom);
			default: return 16'($urandom_range(0, 12));
		endcase
	endfunction

	// Random phases. Each phase programs new settings and then sends mostly well-formed
	// moves: a start followed by about as many ticks as the move needs, or in
	// stop-after-tick mode a run of start and tick pairs. A few moves are cut short by
	// the next start and some requests are plain noise. Long delays come in the last
	// phases only.
	task automatic test_random_moves();
		sss_pkg::run_mode_t mode;
		logic [15:0] delay;
		logic [15:0] goal;
		longint need;
		int sent;
		int ticks;
		for (int ph = 0; ph < 14; ph++) begin
			mode = sss_pkg::run_mode_t'($urandom_range(0, 3));
			if (ph == 12)
				delay = 16'hFFFF;
			else if (ph == 13)
				delay = 16'($urandom_range(4, 65535));
			else
				delay = 16'($urandom_range(0, 3));
			// A delay counter already above the new delay would have to wrap through
			// the whole 16-bit range before the next step, so the delay is raised to it.
			wait_idle();
			if (delay < wait_cnt)
				delay = wait_cnt;
			program_regs(mode, 1'($urandom_range(0, 1)), delay);
			sent = 0;
			while (sent < 100) begin
				if ($urandom_range(0, 9) == 0) begin
					ticks = $urandom_range(1, 3);
					repeat (ticks) send_request(1'($urandom_range(0, 1)), 16'($urandom));
					sent += ticks;
				end else if (mode == sss_pkg::MODE_STOP_AFTER) begin
					goal = pick_target();
					ticks = $urandom_range(1, 6);
					repeat (ticks) begin
						send_request(sss_pkg::CMD_START, goal);
						send_request(sss_pkg::CMD_TICK, 16'($urandom));
					end
					sent += 2 * ticks;
				end else begin
					goal = pick_target();
					need = (longint'(goal) + 1) * (longint'(delay) + 1);
					if (mode == sss_pkg::MODE_CONTINUOUS)
						ticks = $urandom_range(1, 30);
					else if ($urandom_range(0, 7) == 0)
						ticks = $urandom_range(0, 3);
					else if (need > 40)
						ticks = $urandom_range(20, 40);
					else
						ticks = int'(need) + $urandom_range(0, 2);
					send_request(sss_pkg::CMD_START, goal);
					repeat (ticks) send_request(sss_pkg::CMD_TICK, 16'($urandom));
					sent += ticks + 1;
				end
			end
		end
	endtask

	// Runs the delay counter up under the longest delay, then lowers the delay to zero
	// so that the counter sits above it and keeps counting without a step. Runs with no
	// gaps or stalls to keep the cycle count down.
	task automatic test_delay_lowered();
		tx_no_gaps = 1'b1;
		rx_no_stalls = 1'b1;
		program_regs(sss_pkg::MODE_CONTINUOUS, sss_pkg::DIR_CCW, 16'hFFFF);
		send_request(sss_pkg::CMD_START, 16'($urandom));
		repeat (30) send_request(sss_pkg::CMD_TICK, 16'($urandom));
		program_regs(sss_pkg::MODE_CONTINUOUS, sss_pkg::DIR_CW, 16'd0);
		repeat (3) send_request(sss_pkg::CMD_TICK, 16'($urandom));
		tx_no_gaps = 1'b0;
		rx_no_stalls = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.command <= sss_pkg::CMD_TICK;
		in_ch.step_target <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= sss_pkg::CFG_RUN_MODE;
		cfg_ch.value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_backpressure();
		test_random_moves();
		test_delay_lowered();

		wait_idle();
		repeat (5) @(posedge clk);
		if (mismatches == 0 && phase_pos_queue.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				phase_pos_queue.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### files.f
rtl/sss_pkg.sv
rtl/sss_if.sv
rtl/stepper_step_sequencer_core.sv
rtl/sss_checker.sv
dv/stepper_step_sequencer_core_tb.sv
